@@ rtl/core/bps_pkg.sv @@
`timescale 1ns / 1ps

package bps_pkg;

  localparam int unsigned NumPatterns = 5;
  localparam int unsigned MaxSegments = 5;
  localparam int unsigned SegLenBits  = 9;

  // Request kinds carried on the slave tuser
  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_PLAY = 2'd1,
    OP_STOP = 2'd2,
    OP_NONE = 2'd3
  } bps_op_e;

  typedef struct packed {
    bps_op_e     op;
    logic [2:0]  pattern_code;
    logic [31:0] now_ms;
  } bps_item_t;

  typedef struct packed {
    logic drive_on;
    logic playing;
  } bps_result_t;

  // On/off durations in milliseconds, first entry is an ON segment
  localparam logic [SegLenBits-1:0] SEG_TABLE [NumPatterns][MaxSegments] = '{
    '{9'd300, 9'd150, 9'd300, 9'd150, 9'd300},
    '{9'd100, 9'd120, 9'd100, 9'd0,   9'd0  },
    '{9'd100, 9'd120, 9'd250, 9'd0,   9'd0  },
    '{9'd80,  9'd80,  9'd80,  9'd80,  9'd80 },
    '{9'd80,  9'd120, 9'd80,  9'd150, 9'd250}
  };

  localparam logic [2:0] SEG_COUNT [NumPatterns] = '{3'd5, 3'd3, 3'd3, 3'd5, 3'd5};

  function automatic logic pattern_valid(input logic [2:0] sel);
    return (sel >= 3'd1) && (sel <= 3'(NumPatterns));
  endfunction

  // Duration of one segment, zero outside the table
  function automatic logic [SegLenBits-1:0] seg_len(input logic [2:0] sel,
                                                    input logic [2:0] idx);
    logic [2:0] row;
    row = sel - 3'd1;
    if (!pattern_valid(sel) || (idx >= 3'(MaxSegments))) begin
      return '0;
    end
    return SEG_TABLE[row][idx];
  endfunction

  // Number of segments in a pattern, zero for an invalid code
  function automatic logic [2:0] pat_count(input logic [2:0] sel);
    logic [2:0] row;
    row = sel - 3'd1;
    if (!pattern_valid(sel)) begin
      return '0;
    end
    return SEG_COUNT[row];
  endfunction

endpackage

@@ rtl/core/beep_pattern_sequencer.sv @@
// An accepted request is held in the input stage; its result is then registered
// in the output stage, which offers it on the master side. Throughput: one
// request per cycle while the output is not stalled; while the output waits,
// the input stage takes at most one more request and then drops s_axis_tready.
// Reset (rst_ni low, asynchronous) silences the drive, clears the pattern state
// and empties both pipeline stages.
`timescale 1ns / 1ps

module beep_pattern_sequencer import bps_pkg::*; #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // [2:0] pattern_code, [34:3] now_ms, rest zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // [0] drive_on, [1] playing, rest zero
);

  logic        in_valid_q;
  bps_item_t   in_item_q;
  logic        out_valid_q;
  bps_result_t out_res_q;
  logic        advance;
  bps_result_t core_res;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Hold the incoming request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q.op           <= bps_op_e'(s_axis_tuser);
      in_item_q.pattern_code <= s_axis_tdata[2:0];
      in_item_q.now_ms       <= s_axis_tdata[34:3];
    end
  end

  bps_core #(
    .TIME_BITS(TIME_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .item_i  (in_item_q),
    .result_o(core_res)
  );

  // Register the result until the master side takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_res_q.playing, out_res_q.drive_on};

endmodule

@@ rtl/core/bps_core.sv @@
`timescale 1ns / 1ps

module bps_core import bps_pkg::*; #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  bps_item_t   item_i,
  output bps_result_t result_o
);

  logic                 active_q, active_d;
  logic [2:0]           sel_q, sel_d;
  logic [2:0]           seg_idx_q, seg_idx_d;
  logic [TIME_BITS-1:0] deadline_q, deadline_d;
  logic                 drive_q, drive_d;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] diff;
  logic                 reached;
  logic [2:0]           play_count;
  logic [2:0]           cur_count;

  assign now_t      = TIME_BITS'(item_i.now_ms);
  assign diff       = now_t - deadline_q;
  assign reached    = ~diff[TIME_BITS-1];
  assign play_count = pat_count(item_i.pattern_code);
  assign cur_count  = pat_count(sel_q);

  // Work out the state after this request
  always_comb begin
    active_d   = active_q;
    sel_d      = sel_q;
    seg_idx_d  = seg_idx_q;
    deadline_d = deadline_q;
    drive_d    = drive_q;
    case (item_i.op)
      OP_PLAY: begin
        if (pattern_valid(item_i.pattern_code)) begin
          active_d   = 1'b1;
          sel_d      = item_i.pattern_code;
          drive_d    = 1'b1;
          deadline_d = now_t + TIME_BITS'(seg_len(item_i.pattern_code, 3'd0));
          seg_idx_d  = (play_count <= 3'd1) ? play_count : 3'd1;
        end else begin
          active_d  = 1'b0;
          sel_d     = '0;
          seg_idx_d = '0;
          drive_d   = 1'b0;
        end
      end
      OP_STOP: begin
        active_d  = 1'b0;
        sel_d     = '0;
        seg_idx_d = '0;
        drive_d   = 1'b0;
      end
      OP_TICK: begin
        if (active_q && reached) begin
          if (seg_idx_q < cur_count) begin
            drive_d    = ~drive_q;
            deadline_d = now_t + TIME_BITS'(seg_len(sel_q, seg_idx_q));
            seg_idx_d  = seg_idx_q + 3'd1;
          end else begin
            // last segment done: silence and go idle
            active_d  = 1'b0;
            sel_d     = '0;
            seg_idx_d = '0;
            drive_d   = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Hold pattern state, advance once per request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      sel_q      <= '0;
      seg_idx_q  <= '0;
      deadline_q <= '0;
      drive_q    <= 1'b0;
    end else if (step_i) begin
      active_q   <= active_d;
      sel_q      <= sel_d;
      seg_idx_q  <= seg_idx_d;
      deadline_q <= deadline_d;
      drive_q    <= drive_d;
    end
  end

  assign result_o.drive_on = drive_d;
  assign result_o.playing  = active_d;

endmodule
